[hw/rtl/flr_pkg.sv]
// shared constants for the fixed-point line rasterizer
// no dependencies; used by fixed_point_line_rasterizer
`default_nettype none

package flr_pkg;

	// endpoint coordinate width
	localparam int COORD_BITS = 6;
	// fraction bits of the 6.16 slope quotient and of the slope accumulator
	localparam int FRAC_BITS = 16;
	// framebuffer address width and row pitch width
	localparam int ADDR_BITS = 12;
	localparam int PITCH_BITS = 7;
	localparam logic [PITCH_BITS-1:0] PITCH_RESET = PITCH_BITS'(64);

	// pixel count per line reaches 2^COORD_BITS
	localparam int CNT_BITS = COORD_BITS + 1;
	// serial divider: dividend is the minor delta shifted up by the fraction bits
	localparam int DIV_BITS = COORD_BITS + FRAC_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_BITS);
	// slope magnitude is at most one, so it fits fraction bits plus one
	localparam int STEP_BITS = FRAC_BITS + 1;

endpackage

`default_nettype wire

[hw/rtl/fixed_point_line_rasterizer.sv]
// fixed-point line rasterizer: serial slope divider plus dda pixel stepper
// depends on flr_pkg (scoped references)
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  in       | in_valid, in_stall, start_x/y, end_x/y   | request in
//  out      | out_valid, out_stall, pixel_x/y,         | request out
//           | pixel_address, last_pixel                |
//  cfg      | cfg_we, cfg_wdata (row_pitch)            | write only
//
// a line request is accepted while idle; sloped lines then pass through the
// bit-serial restoring divider that forms the 6.16 slope, one quotient
// bit per cycle. after that one pixel leaves per cycle through the output
// register while out_stall does not hold it; axis-parallel lines skip the
// divider. in_stall is high from acceptance of a line with distinct endpoints
// until the last pixel is in the output register. reset clears control and
// sets row_pitch to 64. out_stall holds the output register and pauses stepping.
`default_nettype none

module fixed_point_line_rasterizer (
	input  wire logic clk,
	input  wire logic arst_n,
	// configuration
	input  wire logic cfg_we,
	input  wire logic [flr_pkg::PITCH_BITS-1:0] cfg_wdata,
	// line requests
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [flr_pkg::COORD_BITS-1:0] start_x,
	input  wire logic [flr_pkg::COORD_BITS-1:0] start_y,
	input  wire logic [flr_pkg::COORD_BITS-1:0] end_x,
	input  wire logic [flr_pkg::COORD_BITS-1:0] end_y,
	// pixel requests
	output logic out_valid,
	input  wire logic out_stall,
	output logic [flr_pkg::COORD_BITS-1:0] pixel_x,
	output logic [flr_pkg::COORD_BITS-1:0] pixel_y,
	output logic [flr_pkg::ADDR_BITS-1:0] pixel_address,
	output logic last_pixel
);

	localparam int CB = flr_pkg::COORD_BITS;
	localparam int NB = flr_pkg::CNT_BITS;
	localparam int DB = flr_pkg::DIV_BITS;
	localparam int SB = flr_pkg::STEP_BITS;
	localparam int FB = flr_pkg::FRAC_BITS;
	localparam int AB = flr_pkg::ADDR_BITS;
	localparam int PB = flr_pkg::PITCH_BITS;
	localparam int DCB = flr_pkg::DIV_CNT_BITS;
	localparam int MB = CB + PB;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	logic [1:0] state_q;
	logic [PB-1:0] pitch_q;

	// per-line registers
	logic x_major_q;
	logic neg_q;
	logic [CB-1:0] major_q;
	logic [CB-1:0] minor_q;
	logic [NB-1:0] count_q;
	logic [CB-1:0] den_q;
	logic [CB-1:0] rem_q;
	logic [DB-1:0] quo_q;
	logic [DB-1:0] quo_nx;
	logic [DCB-1:0] div_cnt_q;
	logic [FB-1:0] acc_q;

	// output register
	logic out_valid_q;
	logic [CB-1:0] pix_x_q;
	logic [CB-1:0] pix_y_q;
	logic [AB-1:0] pix_addr_q;
	logic last_q;

	// request decode
	logic accept;
	logic horiz, vert, sloped, y_maj;
	logic [CB-1:0] adx, ady;
	logic [CB-1:0] lo_x, lo_y;
	logic ld_x_major, ld_neg;
	logic [CB-1:0] ld_major, ld_minor, ld_far, ld_num, ld_den;
	logic [NB-1:0] ld_count;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		adx = (start_x < end_x) ? (end_x - start_x) : (start_x - end_x);
		ady = (start_y < end_y) ? (end_y - start_y) : (start_y - end_y);
		lo_x = (start_x < end_x) ? start_x : end_x;
		lo_y = (start_y < end_y) ? start_y : end_y;
		horiz = (start_y == end_y);
		vert = (start_x == end_x);
		sloped = !horiz && !vert;
		y_maj = (adx <= ady);
		ld_far = '0;
		ld_num = adx;
		ld_den = ady;
		priority if (horiz) begin
			ld_x_major = 1'b1;
			ld_major = lo_x;
			ld_minor = start_y;
			ld_count = NB'(adx);
		end else if (vert) begin
			ld_x_major = 1'b0;
			ld_major = lo_y;
			ld_minor = start_x;
			ld_count = NB'(ady);
		end else if (y_maj) begin
			ld_x_major = 1'b0;
			ld_major = lo_y;
			ld_minor = (start_y < end_y) ? start_x : end_x;
			ld_far = (start_y < end_y) ? end_x : start_x;
			ld_count = NB'(ady) + NB'(1);
		end else begin
			ld_x_major = 1'b1;
			ld_major = lo_x;
			ld_minor = (start_x < end_x) ? start_y : end_y;
			ld_far = (start_x < end_x) ? end_y : start_y;
			ld_num = ady;
			ld_den = adx;
			ld_count = NB'(adx) + NB'(1);
		end
		ld_neg = sloped && (ld_far < ld_minor);
	end

	// restoring divider step: one quotient bit per cycle
	logic [CB:0] trial;
	logic trial_ge;
	always_comb begin
		trial = {rem_q, quo_q[DB-1]};
		trial_ge = (trial >= {1'b0, den_q});
		quo_nx = {quo_q[DB-2:0], trial_ge};
	end

	// dda step: accumulate slope, carry moves the minor coordinate
	logic [FB:0] acc_sum;
	logic [CB-1:0] minor_nx;
	logic [CB-1:0] px, py;
	logic [MB-1:0] row_prod;
	logic [AB-1:0] addr;
	logic emit;

	assign emit = (state_q == ST_RUN) && (!out_valid_q || !out_stall);

	always_comb begin
		acc_sum = {1'b0, acc_q} + quo_q[SB-1:0];
		if (acc_sum[FB]) begin
			minor_nx = neg_q ? (minor_q - CB'(1)) : (minor_q + CB'(1));
		end else begin
			minor_nx = minor_q;
		end
		px = x_major_q ? major_q : minor_nx;
		py = x_major_q ? minor_nx : major_q;
		row_prod = MB'(py) * MB'(pitch_q);
		addr = AB'(row_prod) + AB'(px);
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pitch_q <= flr_pkg::PITCH_RESET;
		end else if (cfg_we) begin
			pitch_q <= cfg_wdata;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && !(horiz && vert)) begin
						state_q <= sloped ? ST_DIV : ST_RUN;
					end
				end
				ST_DIV: begin
					if (div_cnt_q == '0) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (emit && count_q == NB'(1)) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// line datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			x_major_q <= ld_x_major;
			neg_q <= ld_neg;
			major_q <= ld_major;
			minor_q <= ld_minor;
			count_q <= ld_count;
			den_q <= ld_den;
			rem_q <= '0;
			quo_q <= sloped ? {ld_num, FB'(0)} : '0;
			div_cnt_q <= DCB'(DB - 1);
			acc_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= trial_ge ? CB'(trial - {1'b0, den_q}) : trial[CB-1:0];
			quo_q <= quo_nx;
			div_cnt_q <= div_cnt_q - DCB'(1);
		end else if (emit) begin
			acc_q <= acc_sum[FB-1:0];
			minor_q <= minor_nx;
			major_q <= major_q + CB'(1);
			count_q <= count_q - NB'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pix_x_q <= px;
			pix_y_q <= py;
			pix_addr_q <= addr;
			last_q <= (count_q == NB'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x = pix_x_q;
	assign pixel_y = pix_y_q;
	assign pixel_address = pix_addr_q;
	assign last_pixel = last_q;

	// checks
	a_run_has_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (count_q != '0))
		else $error("stepping with no pixels left");

	a_slope_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (quo_q <= DB'(1 << FB)))
		else $error("slope magnitude above one");

	a_last_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && count_q == NB'(1)) |=> (state_q == ST_IDLE && last_pixel))
		else $error("final pixel did not end the line");

	a_line_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !(horiz && vert)) |=> (state_q != ST_IDLE))
		else $error("line request dropped");

endmodule

`default_nettype wire
